@@ src/mplt_pkg.sv @@
// Shared types and constants of the MAC port learning table.
package mplt_pkg;

  localparam int MAC_W       = 48;
  localparam int PORT_W      = 8;
  localparam int ENTRIES_DEF = 64;
  localparam int QDEPTH      = 2;

  typedef enum logic [0:0] {
    OP_LOOKUP = 1'b0,
    OP_LEARN  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } req_t;

endpackage

@@ src/mac_port_learning_table_unit.sv @@
// Top level of the MAC port learning table.
// Each request is a lookup (report hit and stored port) or a learn (refresh the
// port of a known address, else insert into the next free slot; a learn into a
// full table is dropped and flagged with table_full). Requests are registered
// at intake and queued two deep ahead of the table engine, which searches the
// stored entries one per cycle through the single read port of the entry
// memory. A request that misses holds the engine until every stored entry has
// been compared, and its result is then registered; a hit ends the search at
// the matching slot, and an empty table goes straight to the result. A result
// that waits at the output holds the engine before it updates the table, and a
// new request is taken while a result waits at the output.
// The table is empty after reset; no clearing pass is needed.
module mac_port_learning_table_unit #(
  parameter int ENTRIES = mplt_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [mplt_pkg::MAC_W-1:0]    in_mac,
  input  logic [mplt_pkg::PORT_W-1:0]   in_port,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [mplt_pkg::PORT_W-1:0]   out_port_out,
  output logic                          out_table_full
);
  import mplt_pkg::*;

  logic push_valid, push_ready, pop_valid, pop_ready;
  req_t push_data, pop_data;

  mplt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .in_mac     (in_mac),
    .in_port    (in_port),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  mplt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_data (push_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data)
  );

  mplt_engine #(
    .ENTRIES(ENTRIES)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_hit       (out_hit),
    .out_port_out  (out_port_out),
    .out_table_full(out_table_full)
  );

endmodule

@@ src/mplt_front.sv @@
// Request intake: accept, classify and stage one request for the queue.
module mplt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [mplt_pkg::MAC_W-1:0]    in_mac,
  input  logic [mplt_pkg::PORT_W-1:0]   in_port,
  output logic                          push_valid,
  input  logic                          push_ready,
  output mplt_pkg::req_t                push_data
);
  import mplt_pkg::*;

  logic vld_r, vld_nxt;
  req_t req_r, req_nxt;
  logic take;

  assign in_ready   = !vld_r || push_ready;
  assign take       = in_valid && in_ready;
  assign push_valid = vld_r;
  assign push_data  = req_r;

  always_comb begin
    vld_nxt = vld_r;
    req_nxt = req_r;
    if (push_ready) begin
      vld_nxt = 1'b0;
    end
    if (take) begin
      vld_nxt      = 1'b1;
      req_nxt.op   = in_req_type ? OP_LEARN : OP_LOOKUP;
      req_nxt.mac  = in_mac;
      req_nxt.port = in_port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

endmodule

@@ src/mplt_queue.sv @@
// Short request queue between intake and table engine.
module mplt_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  mplt_pkg::req_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mplt_pkg::req_t pop_data
);
  import mplt_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(QDEPTH);

  req_t             slots_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign push_ready = cnt_r != FULL;
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = slots_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    priority if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/mplt_engine.sv @@
// Table engine: entry memories, linear search, update and result register.
module mplt_engine #(
  parameter int ENTRIES = mplt_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  mplt_pkg::req_t                pop_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_hit,
  output logic [mplt_pkg::PORT_W-1:0]   out_port_out,
  output logic                          out_table_full
);
  import mplt_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SCAN    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

  logic [MAC_W-1:0]  key_mem  [ENTRIES];
  logic [PORT_W-1:0] port_mem [ENTRIES];
  logic [MAC_W-1:0]  rd_key_r;
  logic [PORT_W-1:0] rd_port_r;

  state_t            state_r, state_nxt;
  req_t              cur_r, cur_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  slot_r, slot_nxt;
  logic [PORT_W-1:0] fport_r, fport_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic [PORT_W-1:0] out_port_r, out_port_nxt;
  logic              out_full_r, out_full_nxt;

  logic              match, rd_en, fire;
  logic              wr_key_en, wr_port_en, ins_en;
  logic [IDX_W-1:0]  wr_addr;

  assign match     = cmp_vld_r && (rd_key_r == cur_r.mac);
  assign rd_en     = (state_r == ST_SCAN) && !match && (issue_r < count_r);
  assign fire      = (state_r == ST_RESOLVE) && (!out_valid_r || out_ready);
  assign pop_ready = state_r == ST_IDLE;

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_port_out   = out_port_r;
  assign out_table_full = out_full_r;

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    issue_nxt   = issue_r;
    count_nxt   = count_r;
    cmp_vld_nxt = rd_en;
    cmp_idx_nxt = issue_r[IDX_W-1:0];
    found_nxt   = found_r;
    slot_nxt    = slot_r;
    fport_nxt   = fport_r;
    out_hit_nxt  = out_hit_r;
    out_port_nxt = out_port_r;
    out_full_nxt = out_full_r;
    wr_key_en   = 1'b0;
    wr_port_en  = 1'b0;
    ins_en      = 1'b0;
    wr_addr     = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          cur_nxt   = pop_data;
          issue_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        priority if (match) begin
          found_nxt = 1'b1;
          slot_nxt  = cmp_idx_r;
          fport_nxt = rd_port_r;
          state_nxt = ST_RESOLVE;
        end else if (!cmp_vld_r && (issue_r == count_r)) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (fire) begin
          state_nxt    = ST_IDLE;
          out_hit_nxt  = found_r;
          out_port_nxt = '0;
          out_full_nxt = 1'b0;
          if (cur_r.op == OP_LOOKUP) begin
            if (found_r) begin
              out_port_nxt = fport_r;
            end
          end else begin
            priority if (found_r) begin
              wr_port_en = 1'b1;
            end else if (count_r < FULL_CNT) begin
              wr_addr    = count_r[IDX_W-1:0];
              wr_key_en  = 1'b1;
              wr_port_en = 1'b1;
              ins_en     = 1'b1;
              count_nxt  = count_r + CNT_W'(1);
            end else begin
              out_full_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = fire || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    issue_r    <= issue_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    found_r    <= found_nxt;
    slot_r     <= slot_nxt;
    fport_r    <= fport_nxt;
    out_hit_r  <= out_hit_nxt;
    out_port_r <= out_port_nxt;
    out_full_r <= out_full_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_key_en) begin
      key_mem[wr_addr] <= cur_r.mac;
    end
    if (wr_port_en) begin
      port_mem[wr_addr] <= cur_r.port;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key_r  <= key_mem[issue_r[IDX_W-1:0]];
      rd_port_r <= port_mem[issue_r[IDX_W-1:0]];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("entry count beyond table size");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> count_r == FULL_CNT && !out_hit_r)
    else $error("table full reported with free slots or on a hit");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not advance entry count");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> state_r == ST_SCAN)
    else $error("compare pending outside of scan");

endmodule
